FILE: sv/ffra_pkg.sv
// Package for the first-fit region allocator: payload structs, status codes,
// slot constants and the microcode ROM of the request sequencer.
// No dependencies; every other file refers to it by scoped names.
package ffra_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int STEP_W     = $clog2(SLOT_COUNT + 1);
  localparam int UPC_W      = 3;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [UPC_W-1:0] UPC_WAIT     = 3'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH = 3'd1;
  localparam logic [UPC_W-1:0] UPC_A_WALK   = 3'd2;
  localparam logic [UPC_W-1:0] UPC_A_COMMIT = 3'd3;
  localparam logic [UPC_W-1:0] UPC_R_WALK   = 3'd4;
  localparam logic [UPC_W-1:0] UPC_R_COMMIT = 3'd5;
  localparam logic [UPC_W-1:0] UPC_EMIT     = 3'd6;

  typedef struct packed {
    logic        op;
    logic [30:0] length;
    logic [31:0] region_start;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] placed_start;
  } rsp_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_OP_REL,
    C_END_A,
    C_END_R
  } cond_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_ADV_A,
    A_COMMIT_A,
    A_ADV_R,
    A_COMMIT_R
  } act_t;

  typedef struct packed {
    cond_t             cond;
    logic [UPC_W-1:0]  target;
    logic              hold;
    act_t              act;
    logic              emit;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{cond: C_ALWAYS, target: UPC_WAIT, hold: 1'b0, act: A_NONE, emit: 1'b0};
    unique case (upc)
      UPC_WAIT:
        w = '{cond: C_NOT_START, target: UPC_WAIT, hold: 1'b0, act: A_LOAD, emit: 1'b0};
      UPC_DISPATCH:
        w = '{cond: C_OP_REL, target: UPC_R_WALK, hold: 1'b0, act: A_NONE, emit: 1'b0};
      UPC_A_WALK:
        w = '{cond: C_END_A, target: UPC_A_COMMIT, hold: 1'b1, act: A_ADV_A, emit: 1'b0};
      UPC_A_COMMIT:
        w = '{cond: C_ALWAYS, target: UPC_EMIT, hold: 1'b0, act: A_COMMIT_A, emit: 1'b0};
      UPC_R_WALK:
        w = '{cond: C_END_R, target: UPC_R_COMMIT, hold: 1'b1, act: A_ADV_R, emit: 1'b0};
      UPC_R_COMMIT:
        w = '{cond: C_NEVER, target: UPC_WAIT, hold: 1'b0, act: A_COMMIT_R, emit: 1'b0};
      UPC_EMIT:
        w = '{cond: C_ALWAYS, target: UPC_WAIT, hold: 1'b0, act: A_NONE, emit: 1'b1};
      default:
        w = '{cond: C_ALWAYS, target: UPC_WAIT, hold: 1'b0, act: A_NONE, emit: 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/first_fit_region_allocator_unit.sv
// First-fit region allocator: sorted slot list, microcoded walk sequencer,
// heap_base register on an APB-style port. Depends on ffra_pkg.
//
//   channel   handshake                    payload
//   request   start & !busy                cmd  (op, length, region_start)
//   response  done, one cycle, no stall    rsp  (status, placed_start)
//   config    psel & penable & pwrite      paddr, pwdata -> heap_base; prdata
//
// After accept, a request steps through dispatch, a walk past at most
// SLOT_COUNT - 1 list regions that holds until its end test is met, then
// commit and emit. busy is low again in the cycle after done. rst is
// synchronous and clears the list, the sequencer and heap_base; no clearing
// pass is needed.
module first_fit_region_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ffra_pkg::cmd_t      cmd,
  output logic                done,
  output ffra_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [ffra_pkg::UPC_W-1:0]  upc;
  logic [ffra_pkg::UPC_W-1:0]  upc_next;
  ffra_pkg::uword_t            uw;
  logic                        take;

  logic [31:0]                 heap_base;
  logic [ffra_pkg::SLOT_W-1:0] link_next   [ffra_pkg::SLOT_COUNT];
  logic                        slot_free   [ffra_pkg::SLOT_COUNT];
  logic [31:0]                 region_base [ffra_pkg::SLOT_COUNT];
  logic [30:0]                 region_size [ffra_pkg::SLOT_COUNT];

  logic                        op;
  logic [30:0]                 len;
  logic [31:0]                 key;
  logic [32:0]                 pos;
  logic [ffra_pkg::SLOT_W-1:0] pre;
  logic [ffra_pkg::SLOT_W-1:0] cur;
  logic [ffra_pkg::STEP_W-1:0] steps;
  logic [1:0]                  status;
  logic [31:0]                 placed_start;

  logic [31:0]                 cur_base;
  logic [30:0]                 cur_size;
  logic [ffra_pkg::SLOT_W-1:0] cur_link;
  logic [33:0]                 gap_end;
  logic                        walk_stop;
  logic                        end_a;
  logic                        end_r;
  logic                        free_hit;
  logic [ffra_pkg::SLOT_W-1:0] free_slot;
  logic                        cfg_write;

  assign uw        = ffra_pkg::ucode_rom(upc);
  assign cur_base  = region_base[cur];
  assign cur_size  = region_size[cur];
  assign cur_link  = link_next[cur];
  assign gap_end   = {1'b0, pos} + {3'b000, len};
  assign walk_stop = (cur == '0) || (steps == ffra_pkg::STEP_W'(ffra_pkg::SLOT_COUNT));
  assign end_a     = walk_stop || (gap_end < {2'b00, cur_base});
  assign end_r     = walk_stop || (cur_base == key);

  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int k = ffra_pkg::SLOT_COUNT - 1; k >= 1; k--) begin
      if (slot_free[k]) begin
        free_hit  = 1'b1;
        free_slot = ffra_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    case (uw.cond)
      ffra_pkg::C_NEVER:     take = 1'b0;
      ffra_pkg::C_ALWAYS:    take = 1'b1;
      ffra_pkg::C_NOT_START: take = !start;
      ffra_pkg::C_OP_REL:    take = (op == ffra_pkg::OP_RELEASE);
      ffra_pkg::C_END_A:     take = end_a;
      ffra_pkg::C_END_R:     take = end_r;
      default:               take = 1'b1;
    endcase
    if (take) begin
      upc_next = uw.target;
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? heap_base : 32'h0;
  assign busy      = (upc != ffra_pkg::UPC_WAIT);
  assign done      = uw.emit;
  assign rsp       = '{status: status, placed_start: placed_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= ffra_pkg::UPC_WAIT;
      heap_base <= '0;
      for (int i = 0; i < ffra_pkg::SLOT_COUNT; i++) begin
        link_next[i] <= '0;
        slot_free[i] <= (i != 0);
      end
    end else begin
      upc <= upc_next;
      if (cfg_write && (paddr[2] == 1'b0)) begin
        heap_base <= pwdata;
      end
      unique case (uw.act)
        ffra_pkg::A_NONE: begin
        end
        ffra_pkg::A_LOAD: begin
          op    <= cmd.op;
          len   <= cmd.length;
          key   <= cmd.region_start;
          pos   <= {1'b0, heap_base};
          pre   <= '0;
          cur   <= link_next[0];
          steps <= '0;
        end
        ffra_pkg::A_ADV_A: begin
          if (!take) begin
            pos   <= {1'b0, cur_base} + {2'b00, cur_size};
            pre   <= cur;
            cur   <= cur_link;
            steps <= steps + 1'b1;
          end
        end
        ffra_pkg::A_COMMIT_A: begin
          if (!free_hit || pos[32]) begin
            status       <= ffra_pkg::ST_NO_SLOT;
            placed_start <= '0;
          end else begin
            slot_free[free_slot]   <= 1'b0;
            link_next[free_slot]   <= cur;
            region_base[free_slot] <= pos[31:0];
            region_size[free_slot] <= len;
            link_next[pre]         <= free_slot;
            status                 <= ffra_pkg::ST_OK;
            placed_start           <= pos[31:0];
          end
        end
        ffra_pkg::A_ADV_R: begin
          if (!take) begin
            pre   <= cur;
            cur   <= cur_link;
            steps <= steps + 1'b1;
          end
        end
        ffra_pkg::A_COMMIT_R: begin
          placed_start <= '0;
          if (!walk_stop && (cur_base == key)) begin
            link_next[pre] <= cur_link;
            link_next[cur] <= '0;
            slot_free[cur] <= 1'b1;
            status         <= ffra_pkg::ST_OK;
          end else begin
            status <= ffra_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: verif/first_fit_region_allocator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for first_fit_region_allocator_unit: directed table, then random
// allocate/release traffic over several heap_base settings, checked by a slot-list predictor.
// Depends on ffra_pkg and the allocator RTL only.
module first_fit_region_allocator_unit_tb;

  localparam logic [2:0] HEAP_BASE_ADDR = 3'd0;
  localparam int         PLAN_LEN       = 20;
  localparam int         PHASES         = 6;
  localparam int         PHASE_ITEMS    = 134;
  localparam int         DRAIN_CYCLES   = 20;
  localparam longint     CYCLE_LIMIT    = 400000;

  localparam logic       OP_A   = ffra_pkg::OP_ALLOC;
  localparam logic       OP_R   = ffra_pkg::OP_RELEASE;
  localparam logic [1:0] S_OK   = ffra_pkg::ST_OK;
  localparam logic [1:0] S_FULL = ffra_pkg::ST_NO_SLOT;
  localparam logic [1:0] S_MISS = ffra_pkg::ST_NOT_FOUND;

  typedef logic [31:0] addr_list_t[$];

  typedef struct {
    bit             cfg;
    logic [31:0]    base_val;
    ffra_pkg::cmd_t c;
    bit             known;
    ffra_pkg::rsp_t want;
  } step_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  ffra_pkg::cmd_t cmd;
  logic           done;
  ffra_pkg::rsp_t rsp;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  logic [ffra_pkg::SLOT_W-1:0] link_q    [ffra_pkg::SLOT_COUNT];
  bit                          vacant    [ffra_pkg::SLOT_COUNT];
  logic [31:0]                 reg_start [ffra_pkg::SLOT_COUNT];
  logic [31:0]                 reg_len   [ffra_pkg::SLOT_COUNT];
  logic [31:0]                 heap_base_q;

  ffra_pkg::rsp_t awaited_rsp[$];
  int             mismatches;
  int             idle_pct;
  longint         cycles;
  step_t          plan [PLAN_LEN];

  first_fit_region_allocator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned follow(int unsigned s);
    int unsigned n;
    if (s >= ffra_pkg::SLOT_COUNT) return 0;
    n = link_q[s];
    return (n < ffra_pkg::SLOT_COUNT) ? n : 0;
  endfunction

  function automatic ffra_pkg::rsp_t place_region(logic [30:0] len);
    longint unsigned pos;
    int unsigned     pre;
    int unsigned     cur;
    int unsigned     steps;
    int unsigned     slot;
    ffra_pkg::rsp_t  r;
    pos   = heap_base_q;
    pre   = 0;
    cur   = follow(0);
    steps = 0;
    slot  = 0;
    r     = '{status: S_FULL, placed_start: 32'd0};
    while (cur != 0 && steps < ffra_pkg::SLOT_COUNT) begin
      if (pos + len < reg_start[cur]) break;
      pos   = longint'(reg_start[cur]) + longint'(reg_len[cur]);
      pre   = cur;
      cur   = follow(cur);
      steps = steps + 1;
    end
    for (int k = 1; k < ffra_pkg::SLOT_COUNT; k++) begin
      if (vacant[k]) begin
        slot = k;
        break;
      end
    end
    if (slot == 0 || pos > 64'hFFFF_FFFF) return r;
    vacant[slot]    = 1'b0;
    link_q[slot]    = ffra_pkg::SLOT_W'(cur);
    reg_start[slot] = pos[31:0];
    reg_len[slot]   = {1'b0, len};
    link_q[pre]     = ffra_pkg::SLOT_W'(slot);
    r.status        = S_OK;
    r.placed_start  = pos[31:0];
    return r;
  endfunction

  function automatic ffra_pkg::rsp_t drop_region(logic [31:0] addr);
    int unsigned    prev;
    int unsigned    cur;
    int unsigned    steps;
    ffra_pkg::rsp_t r;
    prev  = 0;
    cur   = follow(0);
    steps = 0;
    r     = '{status: S_MISS, placed_start: 32'd0};
    while (cur != 0 && steps < ffra_pkg::SLOT_COUNT) begin
      if (reg_start[cur] == addr) begin
        link_q[prev] = ffra_pkg::SLOT_W'(follow(cur));
        link_q[cur]  = '0;
        vacant[cur]  = 1'b1;
        r.status     = S_OK;
        return r;
      end
      prev  = cur;
      cur   = follow(cur);
      steps = steps + 1;
    end
    return r;
  endfunction

  function automatic addr_list_t live_starts();
    addr_list_t  q;
    int unsigned cur;
    int unsigned steps;
    cur   = follow(0);
    steps = 0;
    while (cur != 0 && steps < ffra_pkg::SLOT_COUNT) begin
      q.push_back(reg_start[cur]);
      cur   = follow(cur);
      steps = steps + 1;
    end
    return q;
  endfunction

  task automatic issue(ffra_pkg::cmd_t c, bit known, ffra_pkg::rsp_t want);
    ffra_pkg::rsp_t model_rsp;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy);
    if (c.op == OP_R) model_rsp = drop_region(c.region_start);
    else model_rsp = place_region(c.length);
    awaited_rsp.push_back(known ? want : model_rsp);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (awaited_rsp.size() != 0 || busy);
  endtask

  task automatic write_heap_base(logic [31:0] v);
    settle();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = HEAP_BASE_ADDR;
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    heap_base_q = v;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (prdata !== v) begin
      $error("prdata: expected %h, got %h", v, prdata);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_rsp
    ffra_pkg::rsp_t want;
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected transfer: status %0d placed_start %h", rsp.status, rsp.placed_start);
        mismatches++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.placed_start !== want.placed_start) begin
          $error("placed_start: expected %h, got %h", want.placed_start, rsp.placed_start);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_region_allocator_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    ffra_pkg::cmd_t c;
    addr_list_t     live;
    logic [31:0]    base_val;
    int             k;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    idle_pct    = 0;
    cycles      = 0;
    heap_base_q = '0;
    for (int i = 0; i < ffra_pkg::SLOT_COUNT; i++) begin
      link_q[i]    = '0;
      vacant[i]    = (i != 0);
      reg_start[i] = '0;
      reg_len[i]   = '0;
    end

    plan = '{
      '{1'b1, 32'hFFFF_FFFF, '{OP_A, 31'd0, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'h7FFF_FFFF, 32'd0}, 1'b1, '{S_OK, 32'hFFFF_FFFF}},
      '{1'b0, 32'd0, '{OP_A, 31'd1, 32'hFFFF_FFFF}, 1'b1, '{S_FULL, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd0, 32'd0}, 1'b1, '{S_FULL, 32'd0}},
      '{1'b0, 32'd0, '{OP_R, 31'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{S_OK, 32'd0}},
      '{1'b1, 32'd0, '{OP_A, 31'd0, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd16, 32'd0}, 1'b1, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd0, 32'h0000_0010}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd0, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_R, 31'd0, 32'd16}, 1'b1, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_R, 31'd0, 32'h1234_5678}, 1'b1, '{S_MISS, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd1, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd2, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'h100, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd3, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'h4000_0000, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd5, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'd1, 32'd0}, 1'b0, '{S_OK, 32'd0}},
      '{1'b0, 32'd0, '{OP_A, 31'h7FFF_FFFF, 32'h5A5A_A5A5}, 1'b1, '{S_FULL, 32'd0}},
      '{1'b0, 32'd0, '{OP_R, 31'd0, 32'd0}, 1'b1, '{S_OK, 32'd0}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) write_heap_base(plan[i].base_val);
      else issue(plan[i].c, plan[i].known, plan[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 57;
        default: idle_pct = 13;
      endcase
      case (ph)
        0: base_val = $urandom_range(0, 4096);
        1: base_val = 32'hFFFF_FFFF;
        2: base_val = $urandom;
        3: base_val = 32'd0;
        4: base_val = 32'hFFFF_0000 + $urandom_range(0, 255);
        default: base_val = $urandom;
      endcase
      write_heap_base(base_val);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i % 40 == 39) settle();
        live = live_starts();
        c.region_start = $urandom;
        c.length       = 31'($urandom);
        if ($urandom_range(0, 99) < 70 - 5 * live.size()) begin
          c.op = OP_A;
          k    = $urandom_range(0, 19);
          if (k < 2) c.length = 31'd0;
          else if (k < 14) c.length = 31'($urandom_range(1, 64));
          else if (k > 16) c.length = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
        end else begin
          c.op = OP_R;
          k    = $urandom_range(0, 99);
          if (live.size() != 0 && k < 80) begin
            c.region_start = live[$urandom_range(0, live.size() - 1)];
          end else if (live.size() != 0 && k < 90) begin
            c.region_start = live[$urandom_range(0, live.size() - 1)] + 32'd1;
          end
        end
        issue(c, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("first_fit_region_allocator_unit_tb OK");
    else $display("first_fit_region_allocator_unit_tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ffra_pkg.sv
sv/first_fit_region_allocator_unit.sv
verif/first_fit_region_allocator_unit_tb.sv
